// ===== hw/rtl/ise_pkg.sv =====
package ise_pkg;

   localparam int unsigned VALUE_W = 32;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W = 2;

   // one accepted input word as it travels from front to back
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               last;
   } word_type;

endpackage

// ===== hw/rtl/ise_ram.sv =====
module ise_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== hw/rtl/ise_front.sv =====
module ise_front
   import ise_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [VALUE_W-1:0] req_sort_value,
   input  logic               req_last_item,
   output logic               q_valid,
   output word_type           q_word,
   input  logic               q_pop
);

   word_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]      count_ff, count_in;
   logic                 push;
   logic                 pop;

   assign req_stall = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_word    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff].value <= req_sort_value;
         slot_ff[wr_ptr_ff].last  <= req_last_item;
      end
   end

endmodule

// ===== hw/rtl/ise_back.sv =====
module ise_back
   import ise_pkg::*;
#(
   parameter int unsigned MAX_COUNT = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  word_type           q_word,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [VALUE_W-1:0] rsp_sorted_value,
   output logic               rsp_last_result,
   output logic               rsp_overflowed
);

   localparam int unsigned IDX_W = $clog2(MAX_COUNT);
   localparam int unsigned CNT_W = $clog2(MAX_COUNT + 1);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SHIFT = 6'b000010,
      ST_PLACE = 6'b000100,
      ST_RD    = 6'b001000,
      ST_LD    = 6'b010000,
      ST_HOLD  = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic               drop_ff, drop_in;
   logic               last_ff, last_in;
   logic [IDX_W-1:0]   pos_ff, pos_in;
   logic [VALUE_W-1:0] key_ff, key_in;
   logic [VALUE_W-1:0] out_value_ff;
   logic               out_last_ff;
   logic               out_ovf_ff;
   logic               is_final;

   logic               wr_en, rd_en;
   logic [IDX_W-1:0]   wr_addr, rd_addr;
   logic [VALUE_W-1:0] wr_data, rd_data;

   ise_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_COUNT)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign is_final = ({1'b0, pos_ff} == fill_ff - 1'b1);

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      drop_in  = drop_ff;
      last_in  = last_ff;
      pos_in   = pos_ff;
      key_in   = key_ff;
      q_pop    = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = pos_ff;
      wr_data  = key_ff;
      rd_en    = 1'b0;
      rd_addr  = pos_ff - 1'b1;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               last_in = q_word.last;
               key_in  = q_word.value;
               if (fill_ff == CNT_W'(MAX_COUNT)) begin
                  drop_in  = 1'b1;
                  pos_in   = '0;
                  state_in = q_word.last ? ST_RD : ST_IDLE;
               end else if (fill_ff == '0) begin
                  wr_en    = 1'b1;
                  wr_addr  = '0;
                  wr_data  = q_word.value;
                  fill_in  = CNT_W'(1);
                  pos_in   = '0;
                  state_in = q_word.last ? ST_RD : ST_IDLE;
               end else begin
                  // insertion walk starts at the top of the sorted run
                  pos_in   = fill_ff[IDX_W-1:0];
                  rd_en    = 1'b1;
                  rd_addr  = fill_ff[IDX_W-1:0] - 1'b1;
                  state_in = ST_SHIFT;
               end
            end
         end
         ST_SHIFT: begin
            wr_en = 1'b1;
            if ($signed(rd_data) > $signed(key_ff)) begin
               wr_data = rd_data;
               pos_in  = pos_ff - 1'b1;
               if (pos_ff == IDX_W'(1)) begin
                  state_in = ST_PLACE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = pos_ff - IDX_W'(2);
               end
            end else begin
               fill_in  = fill_ff + 1'b1;
               pos_in   = '0;
               state_in = last_ff ? ST_RD : ST_IDLE;
            end
         end
         ST_PLACE: begin
            wr_en    = 1'b1;
            fill_in  = fill_ff + 1'b1;
            pos_in   = '0;
            state_in = last_ff ? ST_RD : ST_IDLE;
         end
         ST_RD: begin
            rd_en    = 1'b1;
            rd_addr  = pos_ff;
            state_in = ST_LD;
         end
         ST_LD: begin
            state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (!rsp_stall) begin
               if (is_final) begin
                  fill_in  = '0;
                  drop_in  = 1'b0;
                  pos_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  pos_in   = pos_ff + 1'b1;
                  rd_en    = 1'b1;
                  rd_addr  = pos_ff + 1'b1;
                  state_in = ST_LD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         drop_ff  <= 1'b0;
         last_ff  <= 1'b0;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         drop_ff  <= drop_in;
         last_ff  <= last_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (state_ff == ST_LD) begin
         out_value_ff <= rd_data;
         out_last_ff  <= is_final;
         out_ovf_ff   <= drop_ff;
      end
   end

   assign rsp_valid        = (state_ff == ST_HOLD);
   assign rsp_sorted_value = out_value_ff;
   assign rsp_last_result  = out_last_ff;
   assign rsp_overflowed   = out_ovf_ff;

endmodule

// ===== hw/rtl/integer_sort_engine_unit.sv =====
// integer sort engine
// input channel (req_): one signed 32-bit word per transfer, req_last_item
// closes the set. output channel (rsp_): the kept values of the set in
// ascending order, rsp_last_result on the final word, rsp_overflowed on
// every word of a set that had more than MAX_COUNT values.
// a word moves when valid is high and stall is low.
// a four-entry queue in the front takes input words; the back inserts each
// word into a sorted store (one write, one read port), shifting one entry
// per cycle, as its one write port allows. loading a word pops it, reads
// the top stored value, shifts each larger value up and writes the word
// into the gap; the first word of a set and a dropped word need idle only.
// after the last word, results are read, loaded and held on rsp_ in turn;
// the back pops no new input word until the whole set has left.
// a stall on rsp_ holds the result word; the queue keeps taking input
// until it is full, then req_stall rises.
// reset (synchronous, active high) empties the queue and starts a new set;
// the store needs no clearing pass.
module integer_sort_engine_unit
   import ise_pkg::*;
#(
   parameter int unsigned MAX_COUNT = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [VALUE_W-1:0] req_sort_value,
   input  logic               req_last_item,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [VALUE_W-1:0] rsp_sorted_value,
   output logic               rsp_last_result,
   output logic               rsp_overflowed
);

   // queue between front and back
   logic     q_valid;
   logic     q_pop;
   word_type q_word;

   ise_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sort_value (req_sort_value),
      .req_last_item  (req_last_item),
      .q_valid        (q_valid),
      .q_word         (q_word),
      .q_pop          (q_pop)
   );

   // sorter and result stage
   ise_back #(.MAX_COUNT(MAX_COUNT)) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_word           (q_word),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_result  (rsp_last_result),
      .rsp_overflowed   (rsp_overflowed)
   );

endmodule

// ===== hw/rtl/ise_checker.sv =====
module ise_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_sorted_value,
   input logic        rsp_last_result,
   input logic        rsp_overflowed
);

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   a_payload_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_sorted_value) && $stable(rsp_last_result)
         && $stable(rsp_overflowed))
      else $error("rsp word changed while stalled");

   a_gap_after_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> !rsp_valid)
      else $error("result words issued back to back");

   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp_valid right after reset");

endmodule

bind integer_sort_engine_unit ise_checker u_ise_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_sorted_value (rsp_sorted_value),
   .rsp_last_result  (rsp_last_result),
   .rsp_overflowed   (rsp_overflowed)
);
